// ===== design/ltpd_pkg.sv =====
`default_nettype none
package ltpd_pkg;

  localparam int unsigned HDR_BYTES  = 8;
  localparam int unsigned TYPE_SHIFT = 24;
  localparam int unsigned POS_W      = $clog2(HDR_BYTES);
  localparam int unsigned SHIFT_W    = 8 * (HDR_BYTES - 1);

  typedef struct packed {
    logic        emit;
    logic [7:0]  data;
    logic [31:0] mtype;
    logic        empty;
    logic        last;
  } ltpd_res_t;

endpackage
`default_nettype wire

// ===== design/ltpd_core.sv =====
`default_nettype none
module ltpd_core
  import ltpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data,
  output ltpd_res_t       res
);

  logic [POS_W-1:0]   header_count_r, header_count_nxt;
  logic [SHIFT_W-1:0] header_shift_r, header_shift_nxt;
  logic [31:0]        payload_left_r, payload_left_nxt;
  logic [31:0]        type_held_r, type_held_nxt;
  logic [31:0]        len;
  logic [31:0]        typ;

  always_comb begin
    header_count_nxt = header_count_r;
    header_shift_nxt = header_shift_r;
    payload_left_nxt = payload_left_r;
    type_held_nxt    = type_held_r;
    len              = header_shift_r[31:0];
    typ              = {data, header_shift_r[SHIFT_W-1:TYPE_SHIFT+8]};
    res              = '0;
    if (payload_left_r != 32'd0) begin
      res.emit         = 1'b1;
      res.data         = data;
      res.mtype        = type_held_r;
      res.last         = (payload_left_r == 32'd1);
      payload_left_nxt = payload_left_r - 32'd1;
    end else if (header_count_r == POS_W'(HDR_BYTES - 1)) begin
      header_count_nxt = '0;
      header_shift_nxt = '0;
      if (len == 32'd0) begin
        res.emit  = 1'b1;
        res.mtype = typ;
        res.empty = 1'b1;
        res.last  = 1'b1;
      end else begin
        payload_left_nxt = len;
        type_held_nxt    = typ;
      end
    end else begin
      header_count_nxt = header_count_r + POS_W'(1);
      for (int k = 0; k < HDR_BYTES - 1; k++) begin
        if (header_count_r == POS_W'(k)) begin
          header_shift_nxt[8*k +: 8] = data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r <= '0;
      header_shift_r <= '0;
      payload_left_r <= '0;
      type_held_r    <= '0;
    end else if (step) begin
      header_count_r <= header_count_nxt;
      header_shift_r <= header_shift_nxt;
      payload_left_r <= payload_left_nxt;
      type_held_r    <= type_held_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/length_type_prefixed_deframer.sv =====
// A request accepted into the input register passes through the core into the result register when that is free.
// Throughput: one byte per cycle while no result is held waiting for out_ready.
// While a result waits for out_ready, one more request is held in the input register.
// Reset (rst_n low at a clock edge) clears the header count, header bytes,
// remaining payload length, held type and both valid flags.
`default_nettype none
module length_type_prefixed_deframer
  import ltpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_payload_byte,
  output logic [31:0]      out_message_type,
  output logic             out_empty_message,
  output logic             out_last
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic       advance;
  logic       out_free;
  ltpd_res_t  res;
  ltpd_res_t  res_r;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || advance;

  ltpd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .data  (in_byte_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = res_r.data;
  assign out_message_type  = res_r.mtype;
  assign out_empty_message = res_r.empty;
  assign out_last          = res_r.last;

endmodule
`default_nettype wire
